@@ design/pba_pkg.sv @@
// Package for the page bitmap allocator: action and status codes, field widths.
// No dependencies.
`default_nettype none
package pba_pkg;
  localparam int WORD_BITS = 64;

  localparam logic [1:0] ACT_ALLOC  = 2'd0;
  localparam logic [1:0] ACT_EXTEND = 2'd1;
  localparam logic [1:0] ACT_FREE   = 2'd2;
  localparam logic [1:0] ACT_FIND   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [2:0] ST_BLOCKED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_NOT_START = 3'd5;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] page;
    logic [24:0] granted_bytes;
    logic [12:0] pages_in_use;
  } result_t;
endpackage
`default_nettype wire

@@ design/pba_fit.sv @@
// Shared fit unit for the page bitmap allocator: tests one run mask at one
// shift against one bitmap word. Depends on pba_pkg.
`default_nettype none
module pba_fit (
  input  wire logic [63:0] word,
  input  wire logic [5:0]  pgs,
  input  wire logic [5:0]  shift,
  output logic             fits,
  output logic [63:0]      run_mask
);
  logic [63:0] base;
  logic [6:0]  span;
  always_comb begin
    base = (64'd1 << pgs) - 64'd1;
    run_mask = base << shift;
    span = {1'b0, shift} + {1'b0, pgs};
    fits = ((word & run_mask) == 64'd0) && (span <= 7'(pba_pkg::WORD_BITS));
  end
endmodule
`default_nettype wire

@@ design/page_bitmap_allocator.sv @@
// Top level of the page bitmap allocator: stream channels, config register,
// bitmaps in memories and the sequencer. Depends on pba_pkg and pba_fit.
//
// One request beat enters on s_axis (tdata: action, size_bytes, old_size_bytes,
// block_page, byte_offset). One result beat leaves on m_axis (tdata: status,
// page, granted_bytes, pages_in_use). s_axis_tready is high only while the
// sequencer is idle and no result waits; the block handles one request at a
// time. A request is decoded and then walked: allocate reads each word and then
// tests one shift per cycle against it; extend and free read and check one page
// at a time; find reads and checks each page walked back. All of it goes through
// one fit unit and one read port and one write port per bitmap.
// After reset both bitmaps are swept clear, one word a cycle, while s_axis_tready
// stays low; page_count resets to 4096, and the user must write it via cfg_we
// only while no request is in flight; the block does not enforce this. A stalled
// result holds in its register.
`default_nettype none
module page_bitmap_allocator #(
  parameter int PAGES = 4096,
  parameter int PAGE_SHIFT = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [12:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // action[1:0], size_bytes[26:2], old_size_bytes[51:27], block_page[63:52],
  // byte_offset[87:64]
  input  wire logic [87:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[2:0], page[14:3], granted_bytes[39:15], pages_in_use[52:40], zero
  output logic [55:0]      m_axis_tdata
);
  localparam int WORDS = PAGES / 64;
  localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW = WW + 6;

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_DECODE = 4'd2,
    S_ARD = 4'd3, S_ASCAN = 4'd4, S_ERD = 4'd5, S_ECHK = 4'd6,
    S_FRD = 4'd7, S_FCLR = 4'd8, S_NRD = 4'd9, S_NCHK = 4'd10, S_OUT = 4'd11;

  logic [3:0]  state;
  logic [12:0] page_count;
  logic [63:0] used_mem [WORDS];
  logic [63:0] start_mem [WORDS];
  logic [63:0] used_q, start_q;
  logic [WW-1:0] rd_addr;
  logic [WW:0]   word_idx;
  logic [5:0]  shift;
  logic [5:0]  pgs;
  logic [PW:0] pg;
  logic [24:0] count;
  logic [24:0] claimed;
  logic [1:0]  action;
  logic [24:0] size_bytes, old_size_bytes;
  logic [11:0] block_page;
  logic [23:0] byte_offset;
  logic [12:0] used_count;
  pba_pkg::result_t res;

  logic [PW:0] eff;
  logic [WW:0] eff_words;
  logic        fits;
  logic [63:0] run_mask;
  logic [25:0] size_up;
  logic [24:0] new_pgs, old_pgs;
  logic [24:0] ext_start;
  logic [24:0] free_pgs;
  logic [5:0]  bit_sel;
  logic [WW-1:0] pg_word;
  logic        wr_en;
  logic [WW-1:0] wr_addr;
  logic [63:0] used_wr, start_wr;

  always_comb begin
    if (32'(page_count) > PAGES) eff = (PW+1)'(PAGES);
    else eff = (PW+1)'({page_count[12:6], 6'd0});
    eff_words = eff[PW:6];
    size_up = {1'b0, size_bytes} + 26'((1 << PAGE_SHIFT) - 1);
    new_pgs = 25'(size_up >> PAGE_SHIFT);
    old_pgs = old_size_bytes >> PAGE_SHIFT;
    ext_start = {13'd0, block_page} + old_pgs;
    free_pgs = size_bytes >> PAGE_SHIFT;
    bit_sel = pg[5:0];
    pg_word = pg[PW-1:6];
  end

  pba_fit u_fit (.word(used_q), .pgs(pgs), .shift(shift), .fits(fits),
                 .run_mask(run_mask));

  // memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      used_mem[wr_addr] <= used_wr;
      start_mem[wr_addr] <= start_wr;
    end
    used_q <= used_mem[rd_addr];
    start_q <= start_mem[rd_addr];
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = pg_word;
    used_wr = used_q;
    start_wr = start_q;
    rd_addr = pg_word;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = word_idx[WW-1:0];
        used_wr = 64'd0;
        start_wr = 64'd0;
      end
      S_ARD: rd_addr = word_idx[WW-1:0];
      S_ASCAN: begin
        wr_addr = word_idx[WW-1:0];
        rd_addr = word_idx[WW-1:0];
        if (fits) begin
          wr_en = 1'b1;
          used_wr = used_q | run_mask;
          start_wr = start_q | (64'd1 << shift);
        end
      end
      S_ECHK: begin
        if ((pg < eff) && !used_q[bit_sel]) begin
          wr_en = 1'b1;
          used_wr = used_q | (64'd1 << bit_sel);
        end
      end
      S_FCLR: begin
        // a missing start bit ends the free with both maps untouched
        if (count != 25'd0 || start_q[bit_sel]) begin
          wr_en = 1'b1;
          if (count < free_pgs) used_wr = used_q & ~(64'd1 << bit_sel);
          if (count == 25'd0) start_wr = start_q & ~(64'd1 << bit_sel);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      word_idx <= '0;
      page_count <= 13'd4096;
      used_count <= 13'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) page_count <= cfg_wdata;
      case (state)
        S_CLEAR: begin
          word_idx <= word_idx + 1'b1;
          if (word_idx == (WW+1)'(WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            action <= s_axis_tdata[1:0];
            size_bytes <= s_axis_tdata[26:2];
            old_size_bytes <= s_axis_tdata[51:27];
            block_page <= s_axis_tdata[63:52];
            byte_offset <= s_axis_tdata[87:64];
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res.status <= pba_pkg::ST_OK;
          res.page <= 12'd0;
          res.granted_bytes <= 25'd0;
          word_idx <= '0;
          shift <= 6'd0;
          count <= 25'd0;
          claimed <= 25'd0;
          case (action)
            pba_pkg::ACT_ALLOC: begin
              pgs <= new_pgs[5:0];
              if (new_pgs == 25'd0 || new_pgs >= 25'd64) begin
                res.status <= pba_pkg::ST_BAD_SIZE;
                state <= S_OUT;
              end else begin
                res.status <= pba_pkg::ST_NO_SPACE;
                state <= (eff_words == '0) ? S_OUT : S_ARD;
              end
            end
            pba_pkg::ACT_EXTEND: begin
              // clamp a start past the end to the end so it blocks at once
              pg <= (ext_start >= 25'(eff)) ? eff : (PW+1)'(ext_start);
              if (new_pgs > old_pgs) begin
                count <= new_pgs - old_pgs;
                state <= S_ERD;
              end else begin
                res.granted_bytes <= old_size_bytes;
                state <= S_OUT;
              end
            end
            pba_pkg::ACT_FREE: begin
              pg <= (PW+1)'(block_page);
              if ((PW+1)'(block_page) >= eff) begin
                res.status <= pba_pkg::ST_NOT_START;
                state <= S_OUT;
              end else state <= S_FRD;
            end
            default: begin
              pg <= (PW+1)'(byte_offset >> PAGE_SHIFT);
              res.status <= pba_pkg::ST_NOT_FOUND;
              if (((PW+1)'(byte_offset >> PAGE_SHIFT)) >= eff) state <= S_OUT;
              else state <= S_NRD;
            end
          endcase
        end
        S_ARD: state <= S_ASCAN;
        S_ASCAN: begin
          if (fits) begin
            res.status <= pba_pkg::ST_OK;
            res.page <= 12'({word_idx[WW-1:0], shift});
            used_count <= used_count + 13'(pgs);
            state <= S_OUT;
          end else if (shift == 6'd63) begin
            shift <= 6'd0;
            word_idx <= word_idx + 1'b1;
            state <= (word_idx + 1'b1 >= eff_words) ? S_OUT : S_ARD;
          end else shift <= shift + 6'd1;
        end
        S_ERD: state <= S_ECHK;
        S_ECHK: begin
          if ((pg >= eff) || used_q[bit_sel]) begin
            res.status <= pba_pkg::ST_BLOCKED;
            state <= S_OUT;
          end else begin
            used_count <= used_count + 13'd1;
            claimed <= claimed + 25'd1;
            pg <= pg + 1'b1;
            count <= count - 25'd1;
            state <= (count == 25'd1) ? S_OUT : S_ERD;
          end
          if (((pg >= eff) || used_q[bit_sel]) || count == 25'd1) begin
            if ({1'b0, old_size_bytes} + (38'(claimed + ((pg < eff &&
                !used_q[bit_sel]) ? 25'd1 : 25'd0)) << PAGE_SHIFT) > 38'h1FFFFFF)
              res.granted_bytes <= 25'h1FFFFFF;
            else
              res.granted_bytes <= 25'({1'b0, old_size_bytes} +
                (38'(claimed + ((pg < eff && !used_q[bit_sel]) ? 25'd1 : 25'd0))
                << PAGE_SHIFT));
          end
        end
        S_FRD: state <= S_FCLR;
        S_FCLR: begin
          // first visit checks the start bit; count tracks pages done
          if (count == 25'd0 && !start_q[bit_sel]) begin
            res.status <= pba_pkg::ST_NOT_START;
            state <= S_OUT;
          end else begin
            if (count < free_pgs && used_q[bit_sel])
              used_count <= used_count - 13'd1;
            if (count + 25'd1 >= free_pgs || pg + 1'b1 >= eff
                || count >= free_pgs)
              state <= S_OUT;
            else state <= S_FRD;
            count <= count + 25'd1;
            pg <= pg + 1'b1;
          end
        end
        S_NRD: state <= S_NCHK;
        S_NCHK: begin
          if (!used_q[bit_sel]) state <= S_OUT;
          else if (start_q[bit_sel]) begin
            res.status <= pba_pkg::ST_OK;
            res.page <= 12'(pg);
            state <= S_OUT;
          end else if (pg == '0) state <= S_OUT;
          else begin
            pg <= pg - 1'b1;
            state <= S_NRD;
          end
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign m_axis_tdata = {3'd0, used_count, res.granted_bytes, res.page, res.status};
endmodule
`default_nettype wire

@@ design/pba_checker.sv @@
// Port-level checks for the page bitmap allocator, bound to the top level.
// Depends on pba_pkg.
`default_nettype none
module pba_props (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata
);
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
  a_no_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("result too early");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[2:0] <= pba_pkg::ST_NOT_START))
    else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
endmodule

bind page_bitmap_allocator pba_props u_pba_props (.*);
`default_nettype wire

@@ dv/pba_checker.sv @@
// Checker for the page bitmap allocator: watches the request, result and config
// channels, predicts each result and compares it. Depends on pba_pkg.
`default_nettype none
module pba_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [12:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [87:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [55:0] m_axis_tdata,
  output int               errors,
  output int               waiting
);
  import pba_pkg::*;

  localparam int NPAGES = 4096;
  localparam int PSHIFT = 12;
  localparam longint unsigned GRANT_MAX = 64'h1FF_FFFF;

  logic [63:0] used_bits [NPAGES/64];
  logic [63:0] start_bits[NPAGES/64];
  logic [12:0] used_total;
  logic [12:0] page_limit;
  result_t     expected_q[$];

  function automatic bit used_at(int pg);
    return used_bits[pg / 64][pg % 64];
  endfunction

  function automatic bit start_at(int pg);
    return start_bits[pg / 64][pg % 64];
  endfunction

  // Apply one request to the shadow bitmaps and return the result it gives.
  function automatic result_t serve_request(logic [87:0] req);
    logic [1:0]       act;
    longint unsigned  size, old_size, offs, pgs, old_pgs, new_pgs, granted, claimed;
    longint unsigned  mask, pg;
    int               bp, eff, w, s, p;
    bit               found;
    result_t          r;
    act      = req[1:0];
    size     = req[26:2];
    old_size = req[51:27];
    bp       = req[63:52];
    offs     = req[87:64];
    eff      = ((page_limit > NPAGES) ? NPAGES : int'(page_limit)) & ~63;
    r        = '0;
    granted  = 0;
    case (act)
      ACT_ALLOC: begin
        pgs = (size + (1 << PSHIFT) - 1) >> PSHIFT;
        if (pgs == 0 || pgs >= 64) begin
          r.status = ST_BAD_SIZE;
        end else begin
          mask  = (64'd1 << pgs) - 1;
          found = 0;
          r.status = ST_NO_SPACE;
          for (w = 0; w < eff / 64 && !found; w++) begin
            for (s = 0; s <= 64 - int'(pgs) && !found; s++) begin
              if ((used_bits[w] & (mask << s)) == 0) begin
                used_bits[w]  |= mask << s;
                start_bits[w] |= 64'd1 << s;
                used_total += pgs[12:0];
                r.page   = w * 64 + s;
                r.status = ST_OK;
                found    = 1;
              end
            end
          end
        end
      end
      ACT_EXTEND: begin
        old_pgs = old_size >> PSHIFT;
        new_pgs = (size + (1 << PSHIFT) - 1) >> PSHIFT;
        pg      = bp + old_pgs;
        claimed = 0;
        if (new_pgs > old_pgs) begin
          for (longint unsigned i = 0; i < new_pgs - old_pgs; i++) begin
            if (pg >= eff || used_at(int'(pg))) begin
              r.status = ST_BLOCKED;
              break;
            end
            used_bits[pg / 64][pg % 64] = 1'b1;
            used_total++;
            claimed++;
            pg++;
          end
        end
        granted = old_size + (claimed << PSHIFT);
        if (granted > GRANT_MAX) granted = GRANT_MAX;
      end
      ACT_FREE: begin
        if (bp >= eff || !start_at(bp)) begin
          r.status = ST_NOT_START;
        end else begin
          start_bits[bp / 64][bp % 64] = 1'b0;
          p = bp;
          for (longint unsigned i = 0; i < (size >> PSHIFT) && p < eff; i++) begin
            if (used_at(p)) begin
              used_bits[p / 64][p % 64] = 1'b0;
              used_total--;
            end
            p++;
          end
        end
      end
      default: begin
        r.status = ST_NOT_FOUND;
        if (offs < (longint'(eff) << PSHIFT)) begin
          p = int'(offs >> PSHIFT);
          // walk back through used pages until a block start turns up
          forever begin
            if (!used_at(p)) break;
            if (start_at(p)) begin
              r.status = ST_OK;
              r.page   = p;
              break;
            end
            if (p == 0) break;
            p--;
          end
        end
      end
    endcase
    r.granted_bytes = granted[24:0];
    r.pages_in_use  = used_total;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want, got;
    if (rst) begin
      for (int i = 0; i < NPAGES / 64; i++) begin
        used_bits[i]  = '0;
        start_bits[i] = '0;
      end
      used_total = '0;
      page_limit = 13'd4096;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) page_limit = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(serve_request(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status        = m_axis_tdata[2:0];
        got.page          = m_axis_tdata[14:3];
        got.granted_bytes = m_axis_tdata[39:15];
        got.pages_in_use  = m_axis_tdata[52:40];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.page != want.page) begin
            $display("%0t: page exp %0d got %0d", $time, want.page, got.page);
            errors++;
          end
          if (got.granted_bytes != want.granted_bytes) begin
            $display("%0t: granted_bytes exp %0d got %0d", $time,
                     want.granted_bytes, got.granted_bytes);
            errors++;
          end
          if (got.pages_in_use != want.pages_in_use) begin
            $display("%0t: pages_in_use exp %0d got %0d", $time,
                     want.pages_in_use, got.pages_in_use);
            errors++;
          end
        end
      end
    end
    waiting = expected_q.size();
  end
endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench top for the page bitmap allocator: clock, reset, request and
// config stimulus, result-side stalls and the verdict. Depends on pba_pkg,
// pba_checker and page_bitmap_allocator.
`default_nettype none
module tb_top;
  import pba_pkg::*;

  localparam longint CYCLE_LIMIT = 30_000_000;
  localparam int PG = 4096;

  typedef struct {
    logic [11:0] page;
    int          pages;
  } block_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [12:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [55:0] m_axis_tdata;
  int          errors, waiting;
  int          sent = 0, got = 0;
  longint      cycles = 0;

  block_t      live_blocks[$];
  logic [1:0]  issued_act[$];
  int          issued_pages[$];

  page_bitmap_allocator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  pba_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .errors(errors), .waiting(waiting)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("page_bitmap_allocator test failed");
      $finish;
    end
  end

  // Track granted blocks so later requests can aim at real ones.
  always @(posedge clk) begin
    block_t b;
    logic [1:0] a;
    int n;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got++;
      if (issued_act.size() > 0) begin
        a = issued_act.pop_front();
        n = issued_pages.pop_front();
        if (a == ACT_ALLOC && m_axis_tdata[2:0] == ST_OK) begin
          b.page  = m_axis_tdata[14:3];
          b.pages = n;
          live_blocks.push_back(b);
        end
      end
    end
  end

  // Result side: short stalls mostly, a few long ones, and one long hold-off.
  always @(negedge clk) begin
    int stall_left, r;
    bit held;
    if (rst) begin
      m_axis_tready <= 0;
      stall_left = 0;
      held = 0;
    end else if (!held && sent >= 400) begin
      held = 1;
      stall_left = 3000;
      m_axis_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
      r = $urandom_range(0, 99);
      if (r < 8) stall_left = $urandom_range(1, 4);
      else if (r < 10) stall_left = $urandom_range(20, 80);
    end
  end

  task automatic send_req(logic [1:0] act, logic [24:0] size, logic [24:0] old_size,
                          logic [11:0] bp, logic [23:0] offs);
    int r, gap;
    r = $urandom_range(0, 99);
    gap = (r < 10) ? $urandom_range(1, 3) : (r < 12) ? $urandom_range(20, 60) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {offs, bp, old_size, size, act};
    do @(posedge clk); while (!s_axis_tready);
    issued_act.push_back(act);
    issued_pages.push_back((size + PG - 1) / PG);
    sent++;
    @(negedge clk);
  endtask

  task automatic random_req();
    int r, k;
    logic [24:0] sz;
    block_t b;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      // noise: any field value at all
      send_req($urandom_range(0, 3), $urandom & 25'h1FFFFFF, $urandom & 25'h1FFFFFF,
               $urandom & 12'hFFF, $urandom & 24'hFFFFFF);
    end else if (r < 50 || live_blocks.size() == 0) begin
      k = $urandom_range(0, 99);
      sz = (k < 80) ? $urandom_range(1, 8 * PG) : (k < 95) ? $urandom_range(1, 63 * PG)
                    : ($urandom & 25'h1FFFFFF);
      send_req(ACT_ALLOC, sz, 0, 0, 0);
    end else begin
      k = $urandom_range(0, live_blocks.size() - 1);
      b = live_blocks[k];
      if (r < 65) begin
        send_req(ACT_EXTEND, (b.pages + $urandom_range(0, 6)) * PG - $urandom_range(0, 100),
                 b.pages * PG + $urandom_range(0, PG - 1), b.page, 0);
      end else if (r < 82) begin
        // free with slack so pages claimed by extends are swept too
        live_blocks.delete(k);
        send_req(ACT_FREE, (b.pages + $urandom_range(0, 3)) * PG, 0, b.page, 0);
      end else begin
        send_req(ACT_FIND, 0, 0, 0, b.page * PG + $urandom_range(0, (b.pages + 2) * PG - 1));
      end
    end
  endtask

  task automatic write_page_count(logic [12:0] v);
    s_axis_tvalid <= 0;
    @(negedge clk);
    while (got != sent) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we    <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    logic [12:0] settings[7] = '{13'd4096, 13'd64, 13'd8191, 13'd100, 13'd0,
                                 13'd4095, 13'd4096};
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    write_page_count(13'd4096);
    // directed: size extremes, every action and each corner
    send_req(ACT_ALLOC, 0, 0, 0, 0);
    send_req(ACT_ALLOC, 1, 0, 0, 0);
    send_req(ACT_ALLOC, 63 * PG, 0, 0, 0);
    send_req(ACT_ALLOC, 63 * PG + 1, 0, 0, 0);
    send_req(ACT_ALLOC, 25'd16777216, 0, 0, 0);
    send_req(ACT_ALLOC, 25'h1FFFFFF, 0, 0, 0);
    send_req(ACT_FIND, 0, 0, 0, 5 * PG + 7);
    send_req(ACT_FIND, 0, 0, 0, 24'hFFFFFF);
    send_req(ACT_FIND, 0, 0, 0, 100 * PG);
    send_req(ACT_EXTEND, 2 * PG, PG, 0, 0);
    send_req(ACT_EXTEND, 25'd16777216, PG, 0, 0);
    send_req(ACT_EXTEND, 0, 25'd16777216, 0, 0);
    send_req(ACT_EXTEND, 25'h1FFFFFF, 25'h1FFFFFF, 12'd4095, 0);
    send_req(ACT_EXTEND, 3 * PG, 0, 12'd4095, 0);
    send_req(ACT_FREE, PG, 0, 12'd4095, 0);
    send_req(ACT_FREE, PG, 0, 12'd2, 0);
    send_req(ACT_FREE, PG, 0, 12'd0, 0);
    send_req(ACT_FIND, 0, 0, 0, 0);
    send_req(ACT_FREE, 25'd16777216, 0, 12'd1, 0);
    send_req(ACT_FREE, PG, 0, 12'd1, 0);
    send_req(ACT_ALLOC, 2 * PG, 0, 0, 0);
    send_req(ACT_FIND, 0, 0, 0, PG + 1);
    foreach (settings[i]) begin
      write_page_count(settings[i]);
      repeat ((settings[i] == 0) ? 30 : 185) random_req();
    end
    s_axis_tvalid <= 0;
    while (got != sent || waiting != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0 && waiting == 0) begin
      $display("page_bitmap_allocator test passed");
    end else begin
      $display("page_bitmap_allocator test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
